[hdl/usb_control_endpoint_engine_macros.svh]
// Assertion helpers used by the checker in usbcee_checker.sv.
`ifndef USB_CONTROL_ENDPOINT_ENGINE_MACROS_SVH
`define USB_CONTROL_ENDPOINT_ENGINE_MACROS_SVH

// Clocked property, disabled while reset is asserted.
`define USBCEE_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("usb control endpoint check failed");

// Same-cycle implication.
`define USBCEE_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
  `USBCEE_ASSERT(name, clk, rst_n, (ante) |-> (cons))

// Next-cycle implication.
`define USBCEE_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  `USBCEE_ASSERT(name, clk, rst_n, (ante) |=> (cons))

`endif

[hdl/usbcee_pkg.sv]
package usbcee_pkg;

  localparam int unsigned BUFFER_BYTES      = 256;
  localparam int unsigned PACKET_BYTES      = 64;
  localparam int unsigned SERIAL_DESC_BYTES = 62;

  localparam int unsigned NUM_CFG   = 7;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned DLEN_W    = 8;
  localparam int unsigned OFFSET_W  = 9;
  localparam int unsigned LENGTH_W  = 7;

  typedef enum logic [2:0] {
    EV_SETUP,
    EV_IN_DONE,
    EV_OUT_RECEIVED,
    EV_OUT_NAK,
    EV_STALLED,
    EV_BUS_RESET,
    EV_SUSPEND,
    EV_WAKEUP
  } event_e;

  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_STALL,
    ACT_ZLP,
    ACT_DATA
  } action_e;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_STALL,
    PH_STATUS,
    PH_DATA
  } phase_e;

  typedef enum logic [1:0] {
    LINK_DETACHED,
    LINK_DEFAULT,
    LINK_ADDRESSED,
    LINK_CONFIGURED
  } link_e;

  typedef enum logic [2:0] {
    SRC_DEVICE,
    SRC_CONFIG,
    SRC_LANG,
    SRC_MAKER,
    SRC_PRODUCT,
    SRC_SERIAL,
    SRC_HID,
    SRC_REPORT
  } source_e;

  typedef enum logic [1:0] {
    REPLY_STALL,
    REPLY_STATUS,
    REPLY_XMIT
  } reply_e;

  typedef enum logic [2:0] {
    CFG_DEVICE_LEN,
    CFG_CONFIG_LEN,
    CFG_HID_LEN,
    CFG_REPORT_LEN,
    CFG_LANG_LEN,
    CFG_MAKER_LEN,
    CFG_PRODUCT_LEN
  } cfg_reg_e;

  localparam logic [DLEN_W-1:0] CFG_RESET [NUM_CFG] =
    '{8'd18, 8'd41, 8'd9, 8'd34, 8'd4, 8'd2, 8'd2};

  localparam logic [1:0] REQ_TYPE_STANDARD = 2'd0;

  localparam logic [4:0] RCPT_DEVICE    = 5'd0;
  localparam logic [4:0] RCPT_INTERFACE = 5'd1;
  localparam logic [4:0] RCPT_ENDPOINT  = 5'd2;

  localparam logic [7:0] REQ_CLEAR_FEATURE     = 8'h01;
  localparam logic [7:0] REQ_SET_ADDRESS       = 8'h05;
  localparam logic [7:0] REQ_GET_DESCRIPTOR    = 8'h06;
  localparam logic [7:0] REQ_SET_CONFIGURATION = 8'h09;

  localparam logic [7:0] DESC_DEVICE = 8'h01;
  localparam logic [7:0] DESC_CONFIG = 8'h02;
  localparam logic [7:0] DESC_STRING = 8'h03;
  localparam logic [7:0] DESC_HID    = 8'h21;
  localparam logic [7:0] DESC_REPORT = 8'h22;

  localparam logic [7:0] STR_LANG    = 8'd0;
  localparam logic [7:0] STR_MAKER   = 8'd1;
  localparam logic [7:0] STR_PRODUCT = 8'd2;
  localparam logic [7:0] STR_SERIAL  = 8'd3;

  localparam logic [15:0] CONFIG_VALUE_ACTIVE = 16'd1;
  localparam logic [3:0]  MAX_TOGGLE_EP       = 4'd7;

  typedef struct packed {
    reply_e            reply;
    logic              set_address;
    logic [6:0]        address;
    logic              set_config;
    link_e             config_link;
    logic              toggle_valid;
    logic [2:0]        toggle_ep;
    source_e           source;
    logic [DLEN_W-1:0] size;
  } setup_t;

  typedef struct packed {
    action_e             action;
    source_e             source;
    logic [OFFSET_W-1:0] offset;
    logic [LENGTH_W-1:0] length;
    logic                toggle_valid;
    logic [2:0]          toggle_ep;
    link_e               link;
    logic [6:0]          address;
    logic                address_active;
    logic                suspended;
    phase_e              phase;
  } result_t;

endpackage

[hdl/usb_control_endpoint_engine.sv]
// Control endpoint engine for a USB device: one event in, one result out.
// Input channel (in_valid_i / in_stall_o): an event code plus the setup
// fields, which only setup events use. Output channel (out_valid_o /
// out_stall_i): reply action, descriptor chunk (source, offset, length),
// endpoint toggle reset and the link status after the event.
// Config channel (cfg_valid_i / cfg_ready_o): byte lengths of the
// descriptors, always ready; write only while no event is in flight.
// An accepted event is held in the input register; as it leaves, its
// result is loaded into the output register and the state is updated.
// Throughput: one event per cycle while out_stall_i holds no result; a
// new event enters the input register as the previous one leaves it.
// When out_stall_i holds a result, the input register stalls behind it and
// in_stall_o rises; the waiting result stays unchanged until taken.
// Reset: both pipeline registers empty, link detached, address cleared,
// phase idle, descriptor lengths back to their defaults.
module usb_control_endpoint_engine #(
  parameter int unsigned BufferBytes     = usbcee_pkg::BUFFER_BYTES,
  parameter int unsigned PacketBytes     = usbcee_pkg::PACKET_BYTES,
  parameter int unsigned SerialDescBytes = usbcee_pkg::SERIAL_DESC_BYTES
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,

  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [2:0]                       event_code_i,
  input  logic [7:0]                       request_type_i,
  input  logic [7:0]                       request_code_i,
  input  logic [15:0]                      request_value_i,
  input  logic [15:0]                      request_index_i,
  input  logic [15:0]                      request_length_i,

  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [1:0]                       reply_action_o,
  output logic [2:0]                       chunk_source_o,
  output logic [8:0]                       chunk_offset_o,
  output logic [6:0]                       chunk_length_o,
  output logic                             toggle_reset_valid_o,
  output logic [2:0]                       toggle_reset_endpoint_o,
  output logic [1:0]                       link_state_o,
  output logic [6:0]                       bus_address_o,
  output logic                             address_active_o,
  output logic                             is_suspended_o,
  output logic [1:0]                       phase_o,

  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [usbcee_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [usbcee_pkg::DLEN_W-1:0]    cfg_data_i
);

  logic [usbcee_pkg::NUM_CFG-1:0][usbcee_pkg::DLEN_W-1:0] desc_len_q;

  logic                in_vld_q;
  usbcee_pkg::event_e  ev_q;
  logic [7:0]          type_q;
  logic [7:0]          code_q;
  logic [15:0]         value_q;
  logic [15:0]         index_q;
  logic [15:0]         length_q;

  logic                out_vld_q;
  usbcee_pkg::result_t res_q;

  logic                adv;
  logic                in_take;
  usbcee_pkg::setup_t  dec;
  usbcee_pkg::result_t res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < usbcee_pkg::NUM_CFG; i++) begin
        desc_len_q[i] <= usbcee_pkg::CFG_RESET[i];
      end
    end else if (cfg_valid_i && (cfg_index_i < usbcee_pkg::CFG_IDX_W'(usbcee_pkg::NUM_CFG))) begin
      desc_len_q[cfg_index_i] <= cfg_data_i;
    end
  end

  assign adv        = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !adv;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_take) begin
      in_vld_q <= 1'b1;
    end else if (adv) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      ev_q     <= usbcee_pkg::event_e'(event_code_i);
      type_q   <= request_type_i;
      code_q   <= request_code_i;
      value_q  <= request_value_i;
      index_q  <= request_index_i;
      length_q <= request_length_i;
    end
  end

  usbcee_decode #(
    .SerialDescBytes(SerialDescBytes)
  ) u_decode (
    .request_type_i (type_q),
    .request_code_i (code_q),
    .request_value_i(value_q),
    .request_index_i(index_q),
    .desc_len_i     (desc_len_q),
    .dec_o          (dec)
  );

  usbcee_step #(
    .BufferBytes(BufferBytes),
    .PacketBytes(PacketBytes)
  ) u_step (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .event_i  (ev_q),
    .setup_i  (dec),
    .req_len_i(length_q),
    .res_o    (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= res;
    end
  end

  assign out_valid_o             = out_vld_q;
  assign reply_action_o          = res_q.action;
  assign chunk_source_o          = res_q.source;
  assign chunk_offset_o          = res_q.offset;
  assign chunk_length_o          = res_q.length;
  assign toggle_reset_valid_o    = res_q.toggle_valid;
  assign toggle_reset_endpoint_o = res_q.toggle_ep;
  assign link_state_o            = res_q.link;
  assign bus_address_o           = res_q.address;
  assign address_active_o        = res_q.address_active;
  assign is_suspended_o          = res_q.suspended;
  assign phase_o                 = res_q.phase;

endmodule

[hdl/usbcee_decode.sv]
module usbcee_decode #(
  parameter int unsigned SerialDescBytes = usbcee_pkg::SERIAL_DESC_BYTES
) (
  input  logic [7:0]                                            request_type_i,
  input  logic [7:0]                                            request_code_i,
  input  logic [15:0]                                           request_value_i,
  input  logic [15:0]                                           request_index_i,
  input  logic [usbcee_pkg::NUM_CFG-1:0][usbcee_pkg::DLEN_W-1:0] desc_len_i,
  output usbcee_pkg::setup_t                                    dec_o
);

  logic [7:0] dtype;
  logic [7:0] dindex;
  logic [3:0] ep;

  assign dtype  = request_value_i[15:8];
  assign dindex = request_value_i[7:0];
  assign ep     = request_index_i[3:0];

  always_comb begin
    dec_o             = '0;
    dec_o.reply       = usbcee_pkg::REPLY_STALL;
    dec_o.address     = request_value_i[6:0];
    dec_o.config_link = (request_value_i == usbcee_pkg::CONFIG_VALUE_ACTIVE) ?
                        usbcee_pkg::LINK_CONFIGURED : usbcee_pkg::LINK_ADDRESSED;
    if (request_type_i[6:5] == usbcee_pkg::REQ_TYPE_STANDARD) begin
      unique case (request_type_i[4:0])
        usbcee_pkg::RCPT_DEVICE: begin
          unique case (request_code_i)
            usbcee_pkg::REQ_CLEAR_FEATURE: begin
              dec_o.reply = usbcee_pkg::REPLY_STATUS;
            end
            usbcee_pkg::REQ_SET_ADDRESS: begin
              dec_o.set_address = 1'b1;
              dec_o.reply       = usbcee_pkg::REPLY_STATUS;
            end
            usbcee_pkg::REQ_GET_DESCRIPTOR: begin
              unique case (dtype)
                usbcee_pkg::DESC_DEVICE: begin
                  dec_o.reply  = usbcee_pkg::REPLY_XMIT;
                  dec_o.source = usbcee_pkg::SRC_DEVICE;
                  dec_o.size   = desc_len_i[usbcee_pkg::CFG_DEVICE_LEN];
                end
                usbcee_pkg::DESC_CONFIG: begin
                  dec_o.reply  = usbcee_pkg::REPLY_XMIT;
                  dec_o.source = usbcee_pkg::SRC_CONFIG;
                  dec_o.size   = desc_len_i[usbcee_pkg::CFG_CONFIG_LEN];
                end
                usbcee_pkg::DESC_STRING: begin
                  unique case (dindex)
                    usbcee_pkg::STR_LANG: begin
                      dec_o.reply  = usbcee_pkg::REPLY_XMIT;
                      dec_o.source = usbcee_pkg::SRC_LANG;
                      dec_o.size   = desc_len_i[usbcee_pkg::CFG_LANG_LEN];
                    end
                    usbcee_pkg::STR_MAKER: begin
                      dec_o.reply  = usbcee_pkg::REPLY_XMIT;
                      dec_o.source = usbcee_pkg::SRC_MAKER;
                      dec_o.size   = desc_len_i[usbcee_pkg::CFG_MAKER_LEN];
                    end
                    usbcee_pkg::STR_PRODUCT: begin
                      dec_o.reply  = usbcee_pkg::REPLY_XMIT;
                      dec_o.source = usbcee_pkg::SRC_PRODUCT;
                      dec_o.size   = desc_len_i[usbcee_pkg::CFG_PRODUCT_LEN];
                    end
                    usbcee_pkg::STR_SERIAL: begin
                      dec_o.reply  = usbcee_pkg::REPLY_XMIT;
                      dec_o.source = usbcee_pkg::SRC_SERIAL;
                      dec_o.size   = usbcee_pkg::DLEN_W'(SerialDescBytes);
                    end
                    default: ;
                  endcase
                end
                default: ;
              endcase
            end
            usbcee_pkg::REQ_SET_CONFIGURATION: begin
              dec_o.set_config = 1'b1;
              dec_o.reply      = usbcee_pkg::REPLY_STATUS;
            end
            default: ;
          endcase
        end
        usbcee_pkg::RCPT_INTERFACE: begin
          if (request_code_i == usbcee_pkg::REQ_GET_DESCRIPTOR) begin
            if (dtype == usbcee_pkg::DESC_HID) begin
              dec_o.reply  = usbcee_pkg::REPLY_XMIT;
              dec_o.source = usbcee_pkg::SRC_HID;
              dec_o.size   = desc_len_i[usbcee_pkg::CFG_HID_LEN];
            end else if (dtype == usbcee_pkg::DESC_REPORT) begin
              dec_o.reply  = usbcee_pkg::REPLY_XMIT;
              dec_o.source = usbcee_pkg::SRC_REPORT;
              dec_o.size   = desc_len_i[usbcee_pkg::CFG_REPORT_LEN];
            end
          end
        end
        usbcee_pkg::RCPT_ENDPOINT: begin
          if (request_code_i == usbcee_pkg::REQ_CLEAR_FEATURE) begin
            dec_o.reply = usbcee_pkg::REPLY_STATUS;
            if (ep <= usbcee_pkg::MAX_TOGGLE_EP) begin
              dec_o.toggle_valid = 1'b1;
              dec_o.toggle_ep    = ep[2:0];
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule

[hdl/usbcee_step.sv]
module usbcee_step #(
  parameter int unsigned BufferBytes = usbcee_pkg::BUFFER_BYTES,
  parameter int unsigned PacketBytes = usbcee_pkg::PACKET_BYTES
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                adv_i,
  input  usbcee_pkg::event_e  event_i,
  input  usbcee_pkg::setup_t  setup_i,
  input  logic [15:0]         req_len_i,
  output usbcee_pkg::result_t res_o
);

  localparam int unsigned RemW      = $clog2(BufferBytes + 1);
  localparam int unsigned MaxChunks = BufferBytes / PacketBytes;
  localparam int unsigned OffW      = usbcee_pkg::OFFSET_W;

  localparam logic [OffW-1:0] BufLim = OffW'(BufferBytes);
  localparam logic [RemW-1:0] PktLim = RemW'(PacketBytes);

  usbcee_pkg::phase_e  phase_q, phase_d;
  usbcee_pkg::link_e   link_q, link_d;
  usbcee_pkg::source_e source_q, source_d;
  logic                susp_q, susp_d;
  logic [6:0]          addr_q, addr_d;
  logic                aen_q, aen_d;
  logic [RemW-1:0]     rem_q, rem_d;
  logic [OffW-1:0]     off_q, off_d;
  logic                zlp_q, zlp_d;
  logic                armed_q, armed_d;

  logic                awake;
  logic [OffW-1:0]     size_x, size_c, req_c;
  logic [RemW-1:0]     ld_size;
  logic                ld_zlp, size_mult;
  logic                is_setup;
  logic [RemW-1:0]     s_rem, s_n, s_rem_nxt;
  logic [OffW-1:0]     s_off;
  logic                s_zlp;
  usbcee_pkg::action_e s_act;
  logic [RemW-1:0]     s_rem_d;
  logic [OffW-1:0]     s_off_d;
  logic                s_zlp_d, s_more;

  assign awake    = !susp_q;
  assign is_setup = (event_i == usbcee_pkg::EV_SETUP);

  // descriptor length and host request, both clipped to the buffer
  always_comb begin
    size_x = OffW'(setup_i.size);
    size_c = (size_x > BufLim) ? BufLim : size_x;
    req_c  = (req_len_i > 16'(BufferBytes)) ? BufLim : req_len_i[OffW-1:0];
    size_mult = 1'b0;
    for (int k = 0; k <= MaxChunks; k++) begin
      if (size_c == OffW'(k * PacketBytes)) size_mult = 1'b1;
    end
    if (size_c < req_c) begin
      ld_size = RemW'(size_c);
      ld_zlp  = size_mult;
    end else begin
      ld_size = RemW'(req_c);
      ld_zlp  = 1'b0;
    end
  end

  // next packet of the data stage
  always_comb begin
    s_rem     = is_setup ? ld_size : rem_q;
    s_off     = is_setup ? '0 : off_q;
    s_zlp     = is_setup ? ld_zlp : zlp_q;
    s_n       = (s_rem > PktLim) ? PktLim : s_rem;
    s_rem_nxt = s_rem - s_n;
    s_rem_d   = s_rem;
    s_off_d   = s_off;
    s_zlp_d   = s_zlp;
    if (s_rem == '0) begin
      s_act   = s_zlp ? usbcee_pkg::ACT_ZLP : usbcee_pkg::ACT_NONE;
      s_zlp_d = 1'b0;
      s_more  = 1'b0;
    end else begin
      s_act   = usbcee_pkg::ACT_DATA;
      s_rem_d = s_rem_nxt;
      s_off_d = s_off + OffW'(s_n);
      s_more  = !(s_rem_nxt == '0 && !s_zlp);
    end
  end

  always_comb begin
    phase_d  = phase_q;
    link_d   = link_q;
    source_d = source_q;
    susp_d   = susp_q;
    addr_d   = addr_q;
    aen_d    = aen_q;
    rem_d    = rem_q;
    off_d    = off_q;
    zlp_d    = zlp_q;
    armed_d  = armed_q;
    res_o    = '0;
    res_o.action = usbcee_pkg::ACT_NONE;

    unique case (event_i)
      usbcee_pkg::EV_BUS_RESET: begin
        link_d  = usbcee_pkg::LINK_DEFAULT;
        addr_d  = '0;
        aen_d   = 1'b0;
        rem_d   = '0;
        off_d   = '0;
        zlp_d   = 1'b0;
        phase_d = usbcee_pkg::PH_IDLE;
        armed_d = 1'b0;
      end
      usbcee_pkg::EV_SUSPEND: begin
        if (awake) susp_d = 1'b1;
      end
      usbcee_pkg::EV_WAKEUP: begin
        if (!awake) susp_d = 1'b0;
      end
      usbcee_pkg::EV_SETUP: begin
        if (awake) begin
          if (setup_i.set_address) addr_d = setup_i.address;
          if (setup_i.set_config)  link_d = setup_i.config_link;
          unique case (setup_i.reply)
            usbcee_pkg::REPLY_XMIT: begin
              source_d = setup_i.source;
              phase_d  = usbcee_pkg::PH_DATA;
              armed_d  = 1'b1;
              rem_d    = s_rem_d;
              off_d    = s_off_d;
              zlp_d    = s_zlp_d;
              res_o.action = s_act;
            end
            usbcee_pkg::REPLY_STATUS: begin
              phase_d  = usbcee_pkg::PH_STATUS;
              armed_d  = 1'b1;
              res_o.action       = usbcee_pkg::ACT_ZLP;
              res_o.toggle_valid = setup_i.toggle_valid;
              res_o.toggle_ep    = setup_i.toggle_ep;
            end
            default: begin
              phase_d  = usbcee_pkg::PH_STALL;
              armed_d  = 1'b0;
              res_o.action = usbcee_pkg::ACT_STALL;
            end
          endcase
        end
      end
      usbcee_pkg::EV_IN_DONE: begin
        if (awake && armed_q) begin
          if (phase_q == usbcee_pkg::PH_DATA) begin
            rem_d = s_rem_d;
            off_d = s_off_d;
            zlp_d = s_zlp_d;
            res_o.action = s_act;
            if (!s_more) armed_d = 1'b0;
          end else if (phase_q == usbcee_pkg::PH_STATUS) begin
            phase_d = usbcee_pkg::PH_IDLE;
            armed_d = 1'b0;
            if (link_q == usbcee_pkg::LINK_DEFAULT && addr_q != '0) begin
              aen_d  = 1'b1;
              link_d = usbcee_pkg::LINK_ADDRESSED;
            end
          end
        end
      end
      usbcee_pkg::EV_OUT_RECEIVED: begin
        if (awake && phase_q == usbcee_pkg::PH_DATA) begin
          phase_d = usbcee_pkg::PH_IDLE;
          armed_d = 1'b0;
        end
      end
      usbcee_pkg::EV_OUT_NAK: begin
        if (awake && phase_q == usbcee_pkg::PH_DATA) begin
          rem_d = '0;
          zlp_d = 1'b0;
        end
      end
      usbcee_pkg::EV_STALLED: begin
        if (awake) begin
          phase_d = usbcee_pkg::PH_IDLE;
          armed_d = 1'b0;
        end
      end
      default: ;
    endcase

    if (res_o.action == usbcee_pkg::ACT_DATA) begin
      res_o.source = source_d;
      res_o.offset = s_off;
      res_o.length = usbcee_pkg::LENGTH_W'(s_n);
    end
    res_o.link           = link_d;
    res_o.address        = addr_d;
    res_o.address_active = aen_d;
    res_o.suspended      = susp_d;
    res_o.phase          = phase_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= usbcee_pkg::PH_IDLE;
      link_q   <= usbcee_pkg::LINK_DETACHED;
      source_q <= usbcee_pkg::SRC_DEVICE;
      susp_q   <= 1'b0;
      addr_q   <= '0;
      aen_q    <= 1'b0;
      rem_q    <= '0;
      off_q    <= '0;
      zlp_q    <= 1'b0;
      armed_q  <= 1'b0;
    end else if (adv_i) begin
      phase_q  <= phase_d;
      link_q   <= link_d;
      source_q <= source_d;
      susp_q   <= susp_d;
      addr_q   <= addr_d;
      aen_q    <= aen_d;
      rem_q    <= rem_d;
      off_q    <= off_d;
      zlp_q    <= zlp_d;
      armed_q  <= armed_d;
    end
  end

endmodule

[hdl/usbcee_checker.sv]
`include "usb_control_endpoint_engine_macros.svh"

module usbcee_checker #(
  parameter int unsigned PacketBytes = usbcee_pkg::PACKET_BYTES
) (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [1:0] reply_action_o,
  input logic [2:0] chunk_source_o,
  input logic [8:0] chunk_offset_o,
  input logic [6:0] chunk_length_o,
  input logic       toggle_reset_valid_o,
  input logic [1:0] link_state_o,
  input logic       address_active_o,
  input logic [1:0] phase_o
);

  logic        is_data;
  logic        held;
  logic [26:0] out_snap;
  logic        chunk_clear;
  logic        chunk_ok;
  logic        link_ok;
  logic        status_zlp;

  assign is_data     = out_valid_o && (reply_action_o == usbcee_pkg::ACT_DATA);
  assign held        = out_valid_o && out_stall_i;
  assign out_snap    = {reply_action_o, chunk_source_o, chunk_offset_o, chunk_length_o,
                        toggle_reset_valid_o, link_state_o, address_active_o, phase_o};
  assign chunk_clear = (chunk_source_o == '0) && (chunk_offset_o == '0) &&
                       (chunk_length_o == '0);
  assign chunk_ok    = (chunk_length_o != '0) && (chunk_length_o <= 7'(PacketBytes)) &&
                       (phase_o == usbcee_pkg::PH_DATA);
  assign link_ok     = (link_state_o == usbcee_pkg::LINK_ADDRESSED) ||
                       (link_state_o == usbcee_pkg::LINK_CONFIGURED);
  assign status_zlp  = (reply_action_o == usbcee_pkg::ACT_ZLP) &&
                       (phase_o == usbcee_pkg::PH_STATUS);

  `USBCEE_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, held, out_valid_o && $stable(out_snap))

  `USBCEE_ASSERT_IMPL(a_chunk_zero, clk_i, rst_ni, out_valid_o && !is_data, chunk_clear)

  `USBCEE_ASSERT_IMPL(a_chunk_len, clk_i, rst_ni, is_data, chunk_ok)

  `USBCEE_ASSERT_IMPL(a_addr_link, clk_i, rst_ni, out_valid_o && address_active_o, link_ok)

  `USBCEE_ASSERT_IMPL(a_toggle_zlp, clk_i, rst_ni, out_valid_o && toggle_reset_valid_o, status_zlp)

endmodule

bind usb_control_endpoint_engine usbcee_checker #(
  .PacketBytes(PacketBytes)
) u_usbcee_checker (.*);

[verif/usbcee_reply_checker.sv]
module usbcee_reply_checker
  import usbcee_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,

  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  logic [2:0]           event_code_i,
  input  logic [7:0]           request_type_i,
  input  logic [7:0]           request_code_i,
  input  logic [15:0]          request_value_i,
  input  logic [15:0]          request_index_i,
  input  logic [15:0]          request_length_i,

  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  logic [1:0]           reply_action_i,
  input  logic [2:0]           chunk_source_i,
  input  logic [8:0]           chunk_offset_i,
  input  logic [6:0]           chunk_length_i,
  input  logic                 toggle_reset_valid_i,
  input  logic [2:0]           toggle_reset_endpoint_i,
  input  logic [1:0]           link_state_i,
  input  logic [6:0]           bus_address_i,
  input  logic                 address_active_i,
  input  logic                 is_suspended_i,
  input  logic [1:0]           phase_i,

  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [DLEN_W-1:0]    cfg_data_i,

  output int unsigned          mismatch_count_o,
  output int unsigned          pending_count_o
);

  logic [DLEN_W-1:0]   desc_len [NUM_CFG];
  phase_e              phase_q;
  link_e               link_q;
  logic                susp_q;
  logic [6:0]          addr_q;
  logic                addr_en_q;
  logic [OFFSET_W-1:0] remain_q;
  logic [OFFSET_W-1:0] offset_q;
  logic                zlp_q;
  source_e             src_q;
  logic                armed_q;

  result_t     pending_replies [$];
  result_t     want;
  int unsigned mismatches = 0;
  int unsigned pending = 0;

  assign mismatch_count_o = mismatches;
  assign pending_count_o  = pending;

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] exp_val);
    $display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, exp_val);
    mismatches++;
  endtask

  // Next piece of the data stage; returns whether more is to come.
  function automatic bit emit_chunk(inout result_t r);
    int unsigned n;
    n = remain_q;
    if (n == 0) begin
      if (zlp_q) begin
        zlp_q    = 1'b0;
        r.action = ACT_ZLP;
      end
      return 1'b0;
    end
    if (n > PACKET_BYTES) n = PACKET_BYTES;
    r.action = ACT_DATA;
    r.source = src_q;
    r.offset = offset_q;
    r.length = LENGTH_W'(n);
    offset_q = offset_q + OFFSET_W'(n);
    remain_q = remain_q - OFFSET_W'(n);
    return !(remain_q == 0 && !zlp_q);
  endfunction

  function automatic void arm_descriptor(input source_e s, input int unsigned size,
                                         input int unsigned req);
    if (req > BUFFER_BYTES) req = BUFFER_BYTES;
    if (size > BUFFER_BYTES) size = BUFFER_BYTES;
    zlp_q = 1'b0;
    if (size < req) begin
      if (size % PACKET_BYTES == 0) zlp_q = 1'b1;
    end else begin
      size = req;
    end
    remain_q = OFFSET_W'(size);
    offset_q = '0;
    src_q    = s;
    phase_q  = PH_DATA;
    armed_q  = 1'b1;
  endfunction

  function automatic result_t predict_reply(input event_e ev, input logic [7:0] rtype,
                                            input logic [7:0] rcode,
                                            input logic [15:0] rval,
                                            input logic [15:0] ridx,
                                            input logic [15:0] rlen);
    result_t     r;
    reply_e      reply;
    source_e     src;
    int unsigned size;
    logic        awake;
    logic [7:0]  dtype;
    logic [7:0]  dindex;
    r     = '0;
    reply = REPLY_STALL;
    src   = SRC_DEVICE;
    size  = 0;
    awake = !susp_q;
    dtype  = rval[15:8];
    dindex = rval[7:0];
    case (ev)
      EV_BUS_RESET: begin
        link_q    = LINK_DEFAULT;
        addr_q    = '0;
        addr_en_q = 1'b0;
        remain_q  = '0;
        offset_q  = '0;
        zlp_q     = 1'b0;
        phase_q   = PH_IDLE;
        armed_q   = 1'b0;
      end
      EV_SUSPEND: susp_q = 1'b1;
      EV_WAKEUP:  susp_q = 1'b0;
      EV_SETUP: if (awake) begin
        if (rtype[6:5] == REQ_TYPE_STANDARD) begin
          if (rtype[4:0] == RCPT_DEVICE) begin
            if (rcode == REQ_CLEAR_FEATURE) begin
              reply = REPLY_STATUS;
            end else if (rcode == REQ_SET_ADDRESS) begin
              addr_q = rval[6:0];
              reply  = REPLY_STATUS;
            end else if (rcode == REQ_SET_CONFIGURATION) begin
              link_q = (rval == CONFIG_VALUE_ACTIVE) ? LINK_CONFIGURED : LINK_ADDRESSED;
              reply  = REPLY_STATUS;
            end else if (rcode == REQ_GET_DESCRIPTOR) begin
              reply = REPLY_XMIT;
              if (dtype == DESC_DEVICE) begin
                src  = SRC_DEVICE;
                size = desc_len[CFG_DEVICE_LEN];
              end else if (dtype == DESC_CONFIG) begin
                src  = SRC_CONFIG;
                size = desc_len[CFG_CONFIG_LEN];
              end else if (dtype == DESC_STRING && dindex <= STR_PRODUCT) begin
                src  = source_e'(SRC_LANG + dindex[2:0]);
                size = desc_len[CFG_LANG_LEN + dindex[1:0]];
              end else if (dtype == DESC_STRING && dindex == STR_SERIAL) begin
                src  = SRC_SERIAL;
                size = SERIAL_DESC_BYTES;
              end else begin
                reply = REPLY_STALL;
              end
            end
          end else if (rtype[4:0] == RCPT_INTERFACE) begin
            if (rcode == REQ_GET_DESCRIPTOR && dtype == DESC_HID) begin
              reply = REPLY_XMIT;
              src   = SRC_HID;
              size  = desc_len[CFG_HID_LEN];
            end else if (rcode == REQ_GET_DESCRIPTOR && dtype == DESC_REPORT) begin
              reply = REPLY_XMIT;
              src   = SRC_REPORT;
              size  = desc_len[CFG_REPORT_LEN];
            end
          end else if (rtype[4:0] == RCPT_ENDPOINT) begin
            if (rcode == REQ_CLEAR_FEATURE) begin
              if (ridx[3:0] <= MAX_TOGGLE_EP) begin
                r.toggle_valid = 1'b1;
                r.toggle_ep    = ridx[2:0];
              end
              reply = REPLY_STATUS;
            end
          end
        end
        if (reply == REPLY_XMIT) begin
          arm_descriptor(src, size, rlen);
          void'(emit_chunk(r));
        end else if (reply == REPLY_STATUS) begin
          r.action = ACT_ZLP;
          armed_q  = 1'b1;
          phase_q  = PH_STATUS;
        end else begin
          r.action = ACT_STALL;
          phase_q  = PH_STALL;
          armed_q  = 1'b0;
        end
      end
      EV_IN_DONE: if (awake && armed_q) begin
        if (phase_q == PH_DATA) begin
          if (!emit_chunk(r)) armed_q = 1'b0;
        end else if (phase_q == PH_STATUS) begin
          phase_q = PH_IDLE;
          armed_q = 1'b0;
          if (link_q == LINK_DEFAULT && addr_q != 0) begin
            addr_en_q = 1'b1;
            link_q    = LINK_ADDRESSED;
          end
        end
      end
      EV_OUT_RECEIVED: if (awake && phase_q == PH_DATA) begin
        phase_q = PH_IDLE;
        armed_q = 1'b0;
      end
      EV_OUT_NAK: if (awake && phase_q == PH_DATA) begin
        remain_q = '0;
        zlp_q    = 1'b0;
      end
      EV_STALLED: if (awake) begin
        phase_q = PH_IDLE;
        armed_q = 1'b0;
      end
      default: ;
    endcase
    r.link           = link_q;
    r.address        = addr_q;
    r.address_active = addr_en_q;
    r.suspended      = susp_q;
    r.phase          = phase_q;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CFG; i++) desc_len[i] = CFG_RESET[i];
      phase_q   = PH_IDLE;
      link_q    = LINK_DETACHED;
      susp_q    = 1'b0;
      addr_q    = '0;
      addr_en_q = 1'b0;
      remain_q  = '0;
      offset_q  = '0;
      zlp_q     = 1'b0;
      src_q     = SRC_DEVICE;
      armed_q   = 1'b0;
      pending_replies.delete();
      pending = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (pending_replies.size() == 0) begin
          report_mismatch("result with nothing expected, reply_action",
                          16'(reply_action_i), 16'(ACT_NONE));
        end else begin
          want = pending_replies.pop_front();
          if (reply_action_i !== want.action)
            report_mismatch("reply_action", 16'(reply_action_i), 16'(want.action));
          if (chunk_source_i !== want.source)
            report_mismatch("chunk_source", 16'(chunk_source_i), 16'(want.source));
          if (chunk_offset_i !== want.offset)
            report_mismatch("chunk_offset", 16'(chunk_offset_i), 16'(want.offset));
          if (chunk_length_i !== want.length)
            report_mismatch("chunk_length", 16'(chunk_length_i), 16'(want.length));
          if (toggle_reset_valid_i !== want.toggle_valid)
            report_mismatch("toggle_reset_valid", 16'(toggle_reset_valid_i),
                            16'(want.toggle_valid));
          if (toggle_reset_endpoint_i !== want.toggle_ep)
            report_mismatch("toggle_reset_endpoint", 16'(toggle_reset_endpoint_i),
                            16'(want.toggle_ep));
          if (link_state_i !== want.link)
            report_mismatch("link_state", 16'(link_state_i), 16'(want.link));
          if (bus_address_i !== want.address)
            report_mismatch("bus_address", 16'(bus_address_i), 16'(want.address));
          if (address_active_i !== want.address_active)
            report_mismatch("address_active", 16'(address_active_i),
                            16'(want.address_active));
          if (is_suspended_i !== want.suspended)
            report_mismatch("is_suspended", 16'(is_suspended_i), 16'(want.suspended));
          if (phase_i !== want.phase)
            report_mismatch("phase", 16'(phase_i), 16'(want.phase));
        end
      end
      if (in_valid_i && !in_stall_i)
        pending_replies.push_back(predict_reply(event_e'(event_code_i), request_type_i,
                                                request_code_i, request_value_i,
                                                request_index_i, request_length_i));
      if (cfg_valid_i && cfg_ready_i && cfg_index_i < NUM_CFG)
        desc_len[cfg_index_i] = cfg_data_i;
      pending = pending_replies.size();
    end
  end

endmodule

[verif/tb_usb_control_endpoint_engine.sv]
module tb_usb_control_endpoint_engine;
  import usbcee_pkg::*;

  localparam logic [1:0] REQ_TYPE_VENDOR  = 2'd2;
  localparam logic [4:0] RCPT_UNSUPPORTED = 5'h1F;
  localparam logic [7:0] REQ_UNSUPPORTED  = 8'hFF;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;

  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [2:0]           event_code = '0;
  logic [7:0]           request_type = '0;
  logic [7:0]           request_code = '0;
  logic [15:0]          request_value = '0;
  logic [15:0]          request_index = '0;
  logic [15:0]          request_length = '0;

  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [1:0]           reply_action;
  logic [2:0]           chunk_source;
  logic [8:0]           chunk_offset;
  logic [6:0]           chunk_length;
  logic                 toggle_reset_valid;
  logic [2:0]           toggle_reset_endpoint;
  logic [1:0]           link_state;
  logic [6:0]           bus_address;
  logic                 address_active;
  logic                 is_suspended;
  logic [1:0]           phase;

  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DLEN_W-1:0]    cfg_data = '0;

  int unsigned          mismatch_count;
  int unsigned          pending_count;
  int unsigned          events_sent = 0;
  int unsigned          send_idle_pct = 0;
  int unsigned          recv_stall_pct = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  usb_control_endpoint_engine DUT (
    .clk_i                   (clk),
    .rst_ni                  (rst_n),
    .in_valid_i              (in_valid),
    .in_stall_o              (in_stall),
    .event_code_i            (event_code),
    .request_type_i          (request_type),
    .request_code_i          (request_code),
    .request_value_i         (request_value),
    .request_index_i         (request_index),
    .request_length_i        (request_length),
    .out_valid_o             (out_valid),
    .out_stall_i             (out_stall),
    .reply_action_o          (reply_action),
    .chunk_source_o          (chunk_source),
    .chunk_offset_o          (chunk_offset),
    .chunk_length_o          (chunk_length),
    .toggle_reset_valid_o    (toggle_reset_valid),
    .toggle_reset_endpoint_o (toggle_reset_endpoint),
    .link_state_o            (link_state),
    .bus_address_o           (bus_address),
    .address_active_o        (address_active),
    .is_suspended_o          (is_suspended),
    .phase_o                 (phase),
    .cfg_valid_i             (cfg_valid),
    .cfg_ready_o             (cfg_ready),
    .cfg_index_i             (cfg_index),
    .cfg_data_i              (cfg_data)
  );

  usbcee_reply_checker checker_i (
    .clk_i                   (clk),
    .rst_ni                  (rst_n),
    .in_valid_i              (in_valid),
    .in_stall_i              (in_stall),
    .event_code_i            (event_code),
    .request_type_i          (request_type),
    .request_code_i          (request_code),
    .request_value_i         (request_value),
    .request_index_i         (request_index),
    .request_length_i        (request_length),
    .out_valid_i             (out_valid),
    .out_stall_i             (out_stall),
    .reply_action_i          (reply_action),
    .chunk_source_i          (chunk_source),
    .chunk_offset_i          (chunk_offset),
    .chunk_length_i          (chunk_length),
    .toggle_reset_valid_i    (toggle_reset_valid),
    .toggle_reset_endpoint_i (toggle_reset_endpoint),
    .link_state_i            (link_state),
    .bus_address_i           (bus_address),
    .address_active_i        (address_active),
    .is_suspended_i          (is_suspended),
    .phase_i                 (phase),
    .cfg_valid_i             (cfg_valid),
    .cfg_ready_i             (cfg_ready),
    .cfg_index_i             (cfg_index),
    .cfg_data_i              (cfg_data),
    .mismatch_count_o        (mismatch_count),
    .pending_count_o         (pending_count)
  );

  always @(posedge clk) out_stall <= ($urandom_range(99) < recv_stall_pct);

  function automatic logic [7:0] req_type(input logic dir, input logic [4:0] rcpt);
    return {dir, REQ_TYPE_STANDARD, rcpt};
  endfunction

  function automatic logic [15:0] pick_length();
    case ($urandom_range(9))
      0:       return 16'd0;
      1:       return 16'd64;
      2:       return 16'd128;
      3:       return 16'($urandom_range(1, 70));
      4:       return 16'd255;
      5:       return 16'd256;
      6:       return 16'($urandom_range(257, 65535));
      7:       return 16'($urandom);
      default: return 16'($urandom_range(0, 200));
    endcase
  endfunction

  // valid stays high across back-to-back transactions; lowered only for idle cycles
  task automatic send_event(input event_e ev, input logic [7:0] rtype,
                            input logic [7:0] rcode, input logic [15:0] rval,
                            input logic [15:0] ridx, input logic [15:0] rlen);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    event_code     <= ev;
    request_type   <= rtype;
    request_code   <= rcode;
    request_value  <= rval;
    request_index  <= ridx;
    request_length <= rlen;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    events_sent++;
  endtask

  task automatic send_plain(input event_e ev);
    send_event(ev, 8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_count != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic load_desc_lengths(input logic [DLEN_W-1:0] lens [NUM_CFG]);
    for (int i = 0; i <= NUM_CFG; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_data  <= (i < NUM_CFG) ? lens[i] : DLEN_W'($urandom);
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic run_directed();
    send_plain(EV_IN_DONE);
    send_plain(EV_BUS_RESET);
    send_event(EV_SETUP, req_type(1'b0, RCPT_DEVICE), REQ_SET_ADDRESS, 16'hFF7F, 16'h0, 16'h0);
    send_plain(EV_IN_DONE);
    send_event(EV_SETUP, req_type(1'b1, RCPT_DEVICE), REQ_GET_DESCRIPTOR,
               {DESC_DEVICE, 8'h00}, 16'h0, 16'd64);
    send_plain(EV_IN_DONE);
    send_plain(EV_OUT_RECEIVED);
    send_event(EV_SETUP, req_type(1'b1, RCPT_DEVICE), REQ_GET_DESCRIPTOR,
               {DESC_CONFIG, 8'hFF}, 16'hFFFF, 16'hFFFF);
    send_plain(EV_OUT_NAK);
    send_plain(EV_IN_DONE);
    for (int i = 0; i <= 4; i++)
      send_event(EV_SETUP, req_type(1'b1, RCPT_DEVICE), REQ_GET_DESCRIPTOR,
                 {DESC_STRING, 8'(i)}, 16'h0409, 16'd255);
    send_plain(EV_STALLED);
    send_event(EV_SETUP, req_type(1'b1, RCPT_INTERFACE), REQ_GET_DESCRIPTOR,
               {DESC_HID, 8'h00}, 16'h0, 16'h0);
    send_plain(EV_IN_DONE);
    send_event(EV_SETUP, req_type(1'b1, RCPT_INTERFACE), REQ_GET_DESCRIPTOR,
               {DESC_REPORT, 8'h00}, 16'h0, 16'hFFFF);
    send_event(EV_SETUP, req_type(1'b0, RCPT_ENDPOINT), REQ_CLEAR_FEATURE,
               16'h0, 16'hFF87, 16'h0);
    send_event(EV_SETUP, req_type(1'b0, RCPT_ENDPOINT), REQ_CLEAR_FEATURE,
               16'h0, 16'h0008, 16'h0);
    send_event(EV_SETUP, req_type(1'b0, RCPT_DEVICE), REQ_SET_CONFIGURATION,
               CONFIG_VALUE_ACTIVE, 16'h0, 16'h0);
    send_plain(EV_IN_DONE);
    send_event(EV_SETUP, {1'b1, REQ_TYPE_VENDOR, RCPT_DEVICE}, REQ_GET_DESCRIPTOR,
               {DESC_DEVICE, 8'h00}, 16'h0, 16'd18);
    send_event(EV_SETUP, {1'b0, REQ_TYPE_STANDARD, RCPT_UNSUPPORTED}, REQ_CLEAR_FEATURE,
               16'h0, 16'h0, 16'h0);
    send_event(EV_SETUP, req_type(1'b0, RCPT_DEVICE), REQ_UNSUPPORTED, 16'h0, 16'h0, 16'h0);
    send_plain(EV_SUSPEND);
    send_event(EV_SETUP, req_type(1'b0, RCPT_DEVICE), REQ_SET_CONFIGURATION,
               16'h0002, 16'h0, 16'h0);
    send_plain(EV_SUSPEND);
    send_plain(EV_WAKEUP);
    send_plain(EV_WAKEUP);
  endtask

  task automatic pick_descriptor(output logic [7:0] rt, output logic [15:0] rv);
    logic dir;
    dir = 1'($urandom);
    rt  = req_type(dir, RCPT_DEVICE);
    case ($urandom_range(9))
      0:       rv = {DESC_DEVICE, 8'($urandom)};
      1:       rv = {DESC_CONFIG, 8'($urandom)};
      2:       rv = {DESC_STRING, 8'($urandom_range(4, 255))};
      3: begin
        rt = req_type(dir, RCPT_INTERFACE);
        rv = {DESC_HID, 8'($urandom)};
      end
      4: begin
        rt = req_type(dir, RCPT_INTERFACE);
        rv = {DESC_REPORT, 8'($urandom)};
      end
      5:       rv = 16'($urandom);
      6: begin
        rt = 8'($urandom);
        rv = 16'($urandom);
      end
      default: rv = {DESC_STRING, 8'($urandom_range(0, 3))};
    endcase
  endtask

  task automatic random_transfer();
    logic [7:0]  rt;
    logic [15:0] rv;
    int          n;
    pick_descriptor(rt, rv);
    send_event(EV_SETUP, rt, REQ_GET_DESCRIPTOR, rv, 16'($urandom), pick_length());
    n = $urandom_range(0, 6);
    repeat (n) begin
      if ($urandom_range(9) == 0) send_plain(EV_OUT_NAK);
      else send_plain(EV_IN_DONE);
    end
    case ($urandom_range(3))
      0:       send_plain(EV_OUT_RECEIVED);
      1:       send_plain(EV_STALLED);
      default: ;
    endcase
  endtask

  task automatic random_status_request();
    logic [15:0] cfg_val;
    case ($urandom_range(3))
      0: send_event(EV_SETUP, req_type(1'($urandom), RCPT_DEVICE), REQ_SET_ADDRESS,
                    16'($urandom), 16'($urandom), 16'($urandom));
      1: begin
        case ($urandom_range(3))
          0:       cfg_val = 16'h0;
          1:       cfg_val = CONFIG_VALUE_ACTIVE;
          2:       cfg_val = 16'h2;
          default: cfg_val = 16'($urandom);
        endcase
        send_event(EV_SETUP, req_type(1'($urandom), RCPT_DEVICE), REQ_SET_CONFIGURATION,
                   cfg_val, 16'($urandom), 16'($urandom));
      end
      2: send_event(EV_SETUP, req_type(1'($urandom), RCPT_ENDPOINT), REQ_CLEAR_FEATURE,
                    16'($urandom), 16'($urandom), 16'($urandom));
      default: send_event(EV_SETUP, req_type(1'($urandom), RCPT_DEVICE), REQ_CLEAR_FEATURE,
                          16'($urandom), 16'($urandom), 16'($urandom));
    endcase
    if ($urandom_range(4) != 0) send_plain(EV_IN_DONE);
  endtask

  task automatic random_enumeration();
    send_plain(EV_BUS_RESET);
    send_event(EV_SETUP, req_type(1'b0, RCPT_DEVICE), REQ_SET_ADDRESS,
               16'($urandom_range(1, 127)), 16'h0, 16'h0);
    send_plain(EV_IN_DONE);
    if ($urandom_range(1)) begin
      send_event(EV_SETUP, req_type(1'b0, RCPT_DEVICE), REQ_SET_CONFIGURATION,
                 CONFIG_VALUE_ACTIVE, 16'h0, 16'h0);
      send_plain(EV_IN_DONE);
    end
  endtask

  task automatic random_suspend();
    int n;
    send_plain(EV_SUSPEND);
    n = $urandom_range(0, 3);
    repeat (n) send_plain(event_e'($urandom_range(EV_SETUP, EV_SUSPEND)));
    send_plain(EV_WAKEUP);
  endtask

  task automatic run_random(input int unsigned count);
    int unsigned target;
    int unsigned pick;
    target = events_sent + count;
    while (events_sent < target) begin
      pick = $urandom_range(99);
      if (pick < 35) random_transfer();
      else if (pick < 55) random_status_request();
      else if (pick < 65) random_enumeration();
      else if (pick < 75) random_suspend();
      else send_event(event_e'($urandom_range(7)), 8'($urandom), 8'($urandom),
                      16'($urandom), 16'($urandom), 16'($urandom));
    end
  endtask

  initial begin
    logic [DLEN_W-1:0] lens [NUM_CFG];
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    for (int p = 0; p < 6; p++) begin
      drain();
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
        default: begin send_idle_pct = 18; recv_stall_pct = 18; end
      endcase
      for (int i = 0; i < NUM_CFG; i++)
        case (p)
          0:       lens[i] = 8'hFF;
          1:       lens[i] = 8'h00;
          2:       lens[i] = 8'(PACKET_BYTES * (i % 4));
          4:       lens[i] = CFG_RESET[i];
          default: lens[i] = 8'($urandom);
        endcase
      load_desc_lengths(lens);
      run_random(88);
    end
    drain();
    if (mismatch_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

endmodule

[filelist.f]
+incdir+hdl
hdl/usbcee_pkg.sv
hdl/usbcee_decode.sv
hdl/usbcee_step.sv
hdl/usb_control_endpoint_engine.sv
hdl/usbcee_checker.sv
verif/usbcee_reply_checker.sv
verif/tb_usb_control_endpoint_engine.sv
